>>> src/nes_pkg.sv
// ----------------------------------------------------------------------------
// nes_pkg
// shared types and constants for the nearest embedding search block
// ----------------------------------------------------------------------------
package nes_pkg;

  localparam int DIST_W = 38;
  localparam logic [DIST_W-1:0] DIST_MAX = '1;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_SEARCH = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_THR_EN = 2'd1,
    REG_MAXD   = 2'd2,
    REG_K      = 2'd3
  } reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_DRAIN,
    ST_INSERT,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  // control from the sequencer to the distance accumulator
  typedef struct packed {
    logic clear;
    logic acc;
  } acc_ctl_t;

endpackage

>>> src/nes_dist_acc.sv
// ----------------------------------------------------------------------------
// nes_dist_acc
// shared squared-difference unit with a saturating accumulator
// ----------------------------------------------------------------------------
module nes_dist_acc (
  input  logic                          clk,
  input  nes_pkg::acc_ctl_t             ctl,
  input  logic signed [15:0]            qval,
  input  logic signed [15:0]            evalue,
  output logic [nes_pkg::DIST_W-1:0]    sum
);
  import nes_pkg::*;

  logic signed [16:0] diff;
  logic [16:0]        mag;
  logic [33:0]        sq;
  logic [DIST_W:0]    total;
  logic               sq_ok;

  assign diff  = 17'(qval) - 17'(evalue);
  assign mag   = diff[16] ? 17'(-diff) : 17'(diff);
  assign total = {1'b0, sum} + (DIST_W+1)'(sq);

  // square is registered before it is added
  always_ff @(posedge clk) begin
    sq    <= 34'(mag) * 34'(mag);
    sq_ok <= ctl.acc;
    if (ctl.clear) begin
      sum <= '0;
    end else if (sq_ok) begin
      sum <= total[DIST_W] ? DIST_MAX : total[DIST_W-1:0];
    end
  end
endmodule

>>> src/nearest_embedding_search_top.sv
// ----------------------------------------------------------------------------
// nearest_embedding_search_top
// linear squared-distance search over a table of embedding vectors
// ----------------------------------------------------------------------------
// channel  dir  handshake             payload
// s_axis   in   s_axis_tvalid/tready  tdata: cmd, entry_index, element_index, value
// m_axis   out  m_axis_tvalid/tready  tdata: found, match_index, distance_sq, rank;
//                                     tlast: last
// cfg      in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// writes, removals and query loads can follow back to back
// a search skips each invalid entry; each valid entry gets shared multiply-accumulate
// over its DIM elements, then the drain and insert states, the insert shifting the
// list at most KCAP-1 places; the results then go out one per transfer
// reset clears valid marks, registers and control; vector memories are not cleared
// input is held off while a search runs or results wait on m_axis_tready
// ----------------------------------------------------------------------------
module nearest_embedding_search_top #(
  parameter int ENTRIES = 64,
  parameter int DIM     = 64,
  parameter int MAX_K   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // cmd[1:0] entry_index[7:2] element_index[13:8] value[29:14]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // found[0] match_index[6:1] distance_sq[44:7] rank[48:45]
  output logic        m_axis_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [37:0] cfg_data
);
  import nes_pkg::*;

  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int DW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int KCAP = (MAX_K < 16) ? MAX_K : 16;
  localparam int KW = (KCAP > 1) ? $clog2(KCAP) : 1;
  localparam int KCW = $clog2(KCAP + 1);
  localparam int DRAIN = 2;

  // payload fields
  cmd_t               cmd;
  logic [5:0]         in_ent, in_elt;
  logic signed [15:0] in_val;
  assign cmd    = cmd_t'(s_axis_tdata[1:0]);
  assign in_ent = s_axis_tdata[7:2];
  assign in_elt = s_axis_tdata[13:8];
  assign in_val = s_axis_tdata[29:14];

  // configuration registers
  logic              mode, thr_en;
  logic [DIST_W-1:0] max_d;
  logic [4:0]        k_reg;
  logic [KCW-1:0]    cap;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b0; thr_en <= 1'b0; max_d <= '0; k_reg <= 5'd1;
    end else if (cfg_valid) begin
      case (reg_t'(cfg_index))
        REG_MODE:   mode   <= cfg_data[0];
        REG_THR_EN: thr_en <= cfg_data[0];
        REG_MAXD:   max_d  <= cfg_data;
        REG_K:      k_reg  <= cfg_data[4:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    if (k_reg == 5'd0) cap = KCW'(1);
    else if (32'(k_reg) > KCAP) cap = KCW'(KCAP);
    else cap = KCW'(k_reg);
  end

  // sequencer state
  state_t state, state_next;
  logic [EW-1:0] ent;
  logic [DW-1:0] elt;
  logic [1:0]    drain;
  logic [KCW-1:0] n;       // kept entries
  logic [KCW-1:0] pos;     // insert pointer
  logic [KCW-1:0] emit;
  logic           in_acc;

  logic in_fire;
  assign s_axis_tready = (state == ST_IDLE) && !m_axis_tvalid;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // memories
  logic [15:0] evec [ENTRIES*DIM];
  logic [15:0] qvec [DIM];
  logic [15:0] e_rd, q_rd;
  logic [ENTRIES-1:0] valid;

  always_ff @(posedge clk) begin
    if (in_fire && cmd == CMD_WRITE && 32'(in_ent) < ENTRIES && 32'(in_elt) < DIM)
      evec[{in_ent[EW-1:0], in_elt[DW-1:0]}] <= in_val;
    e_rd <= evec[{ent, elt}];
  end
  always_ff @(posedge clk) begin
    if (in_fire && cmd == CMD_QUERY && 32'(in_elt) < DIM)
      qvec[in_elt[DW-1:0]] <= in_val;
    q_rd <= qvec[elt];
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= '0;
    else if (in_fire && 32'(in_ent) < ENTRIES) begin
      if (cmd == CMD_WRITE && 32'(in_elt) < DIM) valid[in_ent[EW-1:0]] <= 1'b1;
      else if (cmd == CMD_REMOVE) valid[in_ent[EW-1:0]] <= 1'b0;
    end
  end

  // shared distance unit
  acc_ctl_t ctl;
  logic [DIST_W-1:0] cur_dist;
  logic rd_ok;
  always_ff @(posedge clk) rd_ok <= in_acc;

  nes_dist_acc u_acc (
    .clk(clk), .ctl(ctl), .qval(q_rd), .evalue(e_rd), .sum(cur_dist)
  );

  // ranked list, one shift step per cycle
  logic [DIST_W-1:0] bd [KCAP];
  logic [5:0]        bi [KCAP];
  logic [KCW-1:0]    pm1;
  logic              shift_go, last_ent, do_ins;
  assign pm1 = pos - KCW'(1);
  assign shift_go = (pos != '0) && (bd[pm1[KW-1:0]] > cur_dist);
  assign last_ent = 32'(ent) == ENTRIES - 1;
  // nearest mode uses the same list with one slot
  assign do_ins = (n < (mode ? cap : KCW'(1))) ||
                  (cur_dist < bd[KW'((mode ? cap : KCW'(1)) - KCW'(1))]);

  // sum is held through the insert and cleared once it is placed or dropped, and while idle
  assign ctl = '{clear: (state == ST_IDLE) ||
                        ((state == ST_INSERT) && !(do_ins && shift_go)),
                 acc:   rd_ok};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_fire && cmd == CMD_SEARCH) state_next = ST_DIST;
      ST_DIST:   if (!valid[ent]) begin
                   if (last_ent) state_next = (n == '0) ? ST_EMPTY : ST_EMIT;
                 end else if (32'(elt) == DIM - 1) state_next = ST_DRAIN;
      ST_DRAIN:  if (drain == 2'(DRAIN)) state_next = ST_INSERT;
      ST_INSERT: if (!do_ins || !shift_go) begin
                   if (last_ent) state_next = (n == '0 && !do_ins) ? ST_EMPTY : ST_EMIT;
                   else state_next = ST_DIST;
                 end
      ST_EMIT:   if (m_axis_tvalid && m_axis_tready && m_axis_tlast) state_next = ST_IDLE;
      ST_EMPTY:  if (m_axis_tvalid && m_axis_tready) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_acc = (state == ST_DIST) && valid[ent];
  end

  logic [KCW-1:0] slot;
  assign slot = (n < (mode ? cap : KCW'(1))) ? n : (mode ? cap : KCW'(1)) - KCW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ent <= '0; elt <= '0; drain <= '0; n <= '0; pos <= '0; emit <= '0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE: begin
          ent <= '0; elt <= '0; n <= '0; emit <= '0; drain <= '0;
        end
        ST_DIST: begin
          if (!valid[ent]) begin
            if (!last_ent) ent <= ent + EW'(1);
          end else if (32'(elt) == DIM - 1) begin
            elt <= '0; drain <= '0;
          end else elt <= elt + DW'(1);
        end
        ST_DRAIN: begin
          drain <= drain + 2'd1;
          pos <= slot;
        end
        ST_INSERT: begin
          if (do_ins && shift_go) begin
            bd[pos[KW-1:0]] <= bd[pm1[KW-1:0]];
            bi[pos[KW-1:0]] <= bi[pm1[KW-1:0]];
            pos <= pm1;
          end else begin
            if (do_ins) begin
              bd[pos[KW-1:0]] <= cur_dist;
              bi[pos[KW-1:0]] <= 6'(ent);
              if (n < (mode ? cap : KCW'(1))) n <= n + KCW'(1);
            end
            if (!last_ent) ent <= ent + EW'(1);
          end
        end
        ST_EMIT: if (m_axis_tvalid && m_axis_tready) emit <= emit + KCW'(1);
        default: ;
      endcase
    end
  end

  // result path
  logic pass;
  assign pass = mode || !thr_en || (bd[0] <= max_d);
  assign m_axis_tvalid = (state == ST_EMIT) || (state == ST_EMPTY);
  always_comb begin
    m_axis_tdata = '0;
    m_axis_tlast = 1'b1;
    if (state == ST_EMIT && pass) begin
      m_axis_tdata[0]     = 1'b1;
      m_axis_tdata[6:1]   = bi[emit[KW-1:0]];
      m_axis_tdata[44:7]  = bd[emit[KW-1:0]];
      m_axis_tdata[48:45] = 4'(emit);
      m_axis_tlast = (emit + KCW'(1) == n);
    end
  end

  // assertions
  a_no_in_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !s_axis_tready) else $error("input taken while busy");
  a_n_cap: assert property (@(posedge clk) disable iff (rst)
    n <= KCW'(KCAP)) else $error("list overfilled");
  a_emit_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (emit < n)) else $error("emit beyond list");
endmodule

>>> bench/nearest_embedding_search_top_tb.sv
// ----------------------------------------------------------------------------
// nearest_embedding_search_top_tb
// self-checking bench for the nearest embedding search block
// ----------------------------------------------------------------------------
// commands stream in on s_axis and search results are checked on m_axis
// against a predictor that keeps its own table, query and registers.
// a search only ever sees entries whose elements were all written first.
// the bench runs a short directed part, then fills a few entries (a tie
// included), then runs random command mixes under several register
// settings and idle patterns.
// ----------------------------------------------------------------------------
module nearest_embedding_search_top_tb;
  import nes_pkg::*;

  localparam int NE = 64;
  localparam int ND = 64;
  localparam int KMAX = 16;
  localparam logic [37:0] MAXD_TOP = 38'd274869518400;

  typedef struct {
    logic        found;
    logic [5:0]  idx;
    logic [37:0] dsq;
    logic [3:0]  rank;
    logic        last;
  } match_t;

  // predictor of the search block plus the queue of pending results
  class match_board;
    logic signed [15:0] vec [NE][ND];
    logic signed [15:0] qry [ND];
    bit                 live [NE];
    logic               mode, thr_en;
    logic [37:0]        maxd;
    logic [4:0]         kreg;
    match_t             pending [$];
    int                 n_checked;
    int                 n_search;

    function void clear_state();
      foreach (live[i]) live[i] = 0;
      mode = 0; thr_en = 0; maxd = '0; kreg = 5'd1;
      pending.delete();
    endfunction

    function void set_reg(reg_t r, logic [37:0] d);
      case (r)
        REG_MODE:   mode = d[0];
        REG_THR_EN: thr_en = d[0];
        REG_MAXD:   maxd = d;
        REG_K:      kreg = d[4:0];
        default:    ;
      endcase
    endfunction

    function logic [37:0] sq_dist(int e);
      longint acc;
      longint df;
      acc = 0;
      for (int i = 0; i < ND; i++) begin
        df = longint'(qry[i]) - longint'(vec[e][i]);
        acc += df * df;
        if (acc > longint'(DIST_MAX)) acc = longint'(DIST_MAX);
      end
      return acc[37:0];
    endfunction

    function void push_match(logic f, int e, logic [37:0] d, int r, logic l);
      match_t m;
      m.found = f; m.idx = e[5:0]; m.dsq = d; m.rank = r[3:0]; m.last = l;
      pending.insert(pending.size(), m);
    endfunction

    // accepted command: update the table or work out a search result
    function void note_item(cmd_t c, logic [5:0] e, logic [5:0] el, logic [15:0] v);
      int cap, n, pos;
      logic [37:0] d, best;
      int bi;
      bit have;
      logic [37:0] ld [KMAX];
      int li [KMAX];
      case (c)
        CMD_WRITE:  begin vec[e][el] = v; live[e] = 1; end
        CMD_REMOVE: live[e] = 0;
        CMD_QUERY:  qry[el] = v;
        CMD_SEARCH: begin
          n_search++;
          if (!mode) begin
            have = 0; best = '0; bi = 0;
            for (int i = 0; i < NE; i++) begin
              if (!live[i]) continue;
              d = sq_dist(i);
              if (!have || d < best) begin have = 1; best = d; bi = i; end
            end
            if (have && (!thr_en || best <= maxd)) push_match(1'b1, bi, best, 0, 1'b1);
            else push_match(1'b0, 0, '0, 0, 1'b1);
          end else begin
            cap = (kreg == 0) ? 1 : int'(kreg);
            if (cap > KMAX) cap = KMAX;
            n = 0;
            for (int i = 0; i < NE; i++) begin
              if (!live[i]) continue;
              d = sq_dist(i);
              if (n < cap) begin pos = n; n++; end
              else if (d < ld[cap-1]) pos = cap - 1;
              else continue;
              while (pos > 0 && ld[pos-1] > d) begin
                ld[pos] = ld[pos-1]; li[pos] = li[pos-1]; pos--;
              end
              ld[pos] = d; li[pos] = i;
            end
            if (n == 0) push_match(1'b0, 0, '0, 0, 1'b1);
            for (int r = 0; r < n; r++) push_match(1'b1, li[r], ld[r], r, r == n - 1);
          end
        end
        default: ;
      endcase
    endfunction

    // returns an empty string on a match, else what differed
    function string check_match(logic f, logic [5:0] e, logic [37:0] d,
                                logic [3:0] r, logic l);
      match_t m;
      if (pending.size() == 0) return "result with nothing expected";
      m = pending.pop_front();
      n_checked++;
      if (f !== m.found || e !== m.idx || d !== m.dsq || r !== m.rank ||
          l !== m.last)
        return $sformatf("got f%0b i%0d d%0d r%0d l%0b exp f%0b i%0d d%0d r%0d l%0b",
                         f, e, d, r, l, m.found, m.idx, m.dsq, m.rank, m.last);
      return "";
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [37:0] cfg_data;

  nearest_embedding_search_top dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  match_board mb;
  int  n_err;
  int  tx_idle_pct;
  int  rx_idle_pct;
  int  n_items;
  bit  filled [NE];   // every element of the entry has been written

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  task automatic report(string msg);
    n_err++;
    $display("mismatch @%0t: %s", $time, msg);
  endtask

  // receive side: random back-pressure, check on every output transfer
  always @(posedge clk) begin
    string s;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        s = mb.check_match(m_axis_tdata[0], m_axis_tdata[6:1], m_axis_tdata[44:7],
                           m_axis_tdata[48:45], m_axis_tlast);
        if (s != "") report(s);
      end
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // one command transfer; valid stays high into the next call unless it idles
  task automatic send(cmd_t c, logic [5:0] e, logic [5:0] el, logic [15:0] v);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, v, el, e, c};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    mb.note_item(c, e, el, v);
    n_items++;
  endtask

  // fill a whole entry; a copy of another entry gives a distance tie
  task automatic fill_entry(int e, int src, bit extreme, logic [15:0] xv);
    logic [15:0] v;
    for (int i = 0; i < ND; i++) begin
      if (extreme) v = xv;
      else if (src >= 0) v = mb.vec[src][i];
      else v = 16'($urandom());
      send(CMD_WRITE, e[5:0], i[5:0], v);
    end
    filled[e] = 1;
  endtask

  // register write with the block drained and idle
  task automatic set_reg(reg_t r, logic [37:0] d);
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (mb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mb.set_reg(r, d);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [37:0] rand_maxd();
    logic [37:0] m;
    m = 38'({$urandom(), $urandom()});
    return (m > MAXD_TOP) ? m - MAXD_TOP : m;
  endfunction

  task automatic random_mix(int count);
    int stop, r, e;
    stop = n_items + count;
    while (n_items < stop) begin
      r = $urandom_range(99);
      if (r < 35) begin
        // element rewrite of a filled entry, revalidates it if removed
        do e = $urandom_range(NE - 1); while (!filled[e]);
        send(CMD_WRITE, e[5:0], 6'($urandom_range(ND - 1)), 16'($urandom()));
      end else if (r < 50) begin
        send(CMD_REMOVE, 6'($urandom_range(NE - 1)), 6'($urandom()), 16'($urandom()));
      end else if (r < 70) begin
        send(CMD_QUERY, 6'($urandom()), 6'($urandom_range(ND - 1)), 16'($urandom()));
      end else begin
        send(CMD_SEARCH, 6'($urandom()), 6'($urandom()), 16'($urandom()));
      end
    end
  endtask

  initial begin
    mb = new();
    mb.clear_state();
    n_err = 0; n_items = 0;
    tx_idle_pct = 12; rx_idle_pct = 68;
    foreach (filled[i]) filled[i] = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0; cfg_index = REG_MODE; cfg_data = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, then max distance, then zero distance
    send(CMD_SEARCH, 6'h3f, 6'h3f, 16'hffff);
    send(CMD_REMOVE, 6'h3f, 6'h00, 16'h0000);
    fill_entry(0, -1, 1, 16'h7fff);
    for (int i = ND - 1; i >= 0; i--) send(CMD_QUERY, 6'h00, i[5:0], 16'h8000);
    send(CMD_SEARCH, 6'h00, 6'h00, 16'h0000);
    fill_entry(63, -1, 1, 16'h8000);
    send(CMD_SEARCH, 6'h00, 6'h00, 16'h0000);
    send(CMD_REMOVE, 6'h3f, 6'h00, 16'h0000);
    send(CMD_SEARCH, 6'h00, 6'h00, 16'h0000);
    send(CMD_REMOVE, 6'h00, 6'h00, 16'h0000);
    send(CMD_SEARCH, 6'h00, 6'h00, 16'h0000);

    // k mode with the largest k, two entries with the same vector
    set_reg(REG_MODE, 38'd1);
    set_reg(REG_K, 38'd16);
    fill_entry(5, -1, 0, '0);
    fill_entry(9, 5, 0, '0);    // tie with entry 5
    send(CMD_SEARCH, 6'h00, 6'h00, 16'h0000);
    random_mix(24);

    // settings sweep with the three idle patterns in turn
    for (int p = 0; p < 6; p++) begin
      case (p % 3)
        0: begin tx_idle_pct = 68; rx_idle_pct = 12; end
        1: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
        2: begin tx_idle_pct = 12; rx_idle_pct = 68; end
        default: ;
      endcase
      case (p)
        0: begin set_reg(REG_MODE, 38'd0); set_reg(REG_THR_EN, 38'd1);
                 set_reg(REG_MAXD, 38'd0); end
        1: begin set_reg(REG_MAXD, MAXD_TOP); end
        2: begin set_reg(REG_MAXD, rand_maxd()); end
        3: begin set_reg(REG_MODE, 38'd1); set_reg(REG_K, 38'd1); end
        4: begin set_reg(REG_K, 38'($urandom_range(2, 15))); end
        5: begin set_reg(REG_MODE, 38'd0); set_reg(REG_THR_EN, 38'd0); end
        default: ;
      endcase
      random_mix(11);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (mb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("ran %0d command transfers, %0d searches, %0d results checked",
             n_items, mb.n_search, mb.n_checked);
    $display("covered nearest with and without limit, k of 1 to 16, ties, empty table");
    if (n_err == 0 && mb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // hang guard, far beyond the slowest correct run
  initial begin
    #(12 * 8_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> files.f
src/nes_pkg.sv
src/nes_dist_acc.sv
src/nearest_embedding_search_top.sv
bench/nearest_embedding_search_top_tb.sv
